>>> design/pfa_pkg.sv
package pfa_pkg;

    localparam int FRAMES      = 64;
    localparam int MAX_REQUEST = 16;
    localparam int ID_BITS     = 8;
    localparam int FRAME_BITS  = $clog2(FRAMES);
    localparam int FREE_BITS   = $clog2(FRAMES + 1);
    localparam int COUNT_BITS  = 5;
    localparam int CMD_DEPTH   = 2;
    localparam int RES_DEPTH   = 4;

    typedef enum logic [1:0] {
        ST_ASSIGNED = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RELEASED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_RELEASE = 2'd1,
        K_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SWEEP,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [ID_BITS-1:0]     id;
        logic [COUNT_BITS-1:0]  count;
    } t_cmd;

    typedef struct packed {
        t_status                status;
        logic [COUNT_BITS-1:0]  logical_page;
        logic [FRAME_BITS-1:0]  frame;
        logic [FREE_BITS-1:0]   free_frames;
        logic                   last;
    } t_result;

    // lowest free frame
    function automatic logic [FRAME_BITS-1:0] first_free(input logic [FRAMES-1:0] used);
        logic [FRAME_BITS-1:0] idx;
        idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (!used[i]) begin
                idx = FRAME_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> design/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/pfa_front.sv
module pfa_front import pfa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_action,
    input  logic [ID_BITS-1:0]     i_requester_id,
    input  logic [COUNT_BITS-1:0]  i_page_count,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  logic                   i_cmd_pop
);

    localparam int PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CNT_BITS = $clog2(CMD_DEPTH + 1);

    t_cmd                r_mem [CMD_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    t_cmd                cls;
    logic                wr_en, rd_en;

    always_comb begin
        cls.id    = i_requester_id;
        cls.count = i_page_count;
        if (i_action) begin
            cls.kind = K_RELEASE;
        end else if (i_page_count == '0 ||
                     i_page_count > COUNT_BITS'(MAX_REQUEST)) begin
            cls.kind = K_REJECT;
        end else begin
            cls.kind = K_ALLOC;
        end
    end

    assign full        = (r_cnt == CNT_BITS'(CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign wr_en       = push && !full;
    assign rd_en       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cls;
        end
    end

endmodule

>>> design/pfa_back.sv
module pfa_back import pfa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(FRAMES - 1);

    t_state                 r_state, n_state;
    logic [FRAMES-1:0]      r_used, n_used;
    logic [FREE_BITS-1:0]   r_free, n_free;
    logic [ID_BITS-1:0]     r_id, n_id;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [COUNT_BITS-1:0]  r_given, n_given;
    logic [FRAME_BITS-1:0]  r_idx, n_idx;
    logic                   r_chk, n_chk;
    logic [FRAME_BITS-1:0]  r_chk_idx, n_chk_idx;

    logic [FRAME_BITS-1:0]  first;
    logic                   short_space;
    logic                   alloc_last;
    logic                   chk_hit;
    logic                   ram_we;
    logic [ID_BITS-1:0]     ram_rdata;

    assign first       = first_free(r_used);
    assign short_space = FREE_BITS'(i_cmd.count) > r_free;
    assign alloc_last  = (r_given + 1'b1) == r_count;
    assign chk_hit     = r_chk && r_used[r_chk_idx] && (ram_rdata == r_id);

    pfa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (FRAMES)
    ) u_owner (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (first),
        .i_wdata (r_id),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_res_ready) begin
                    if (i_cmd.kind == K_ALLOC && !short_space) begin
                        n_state = S_ALLOC;
                    end else if (i_cmd.kind == K_RELEASE) begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_ALLOC: begin
                if (i_res_ready && alloc_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (r_idx == LAST_FRAME) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (!r_chk && i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_used      = r_used;
        n_free      = r_free;
        n_id        = r_id;
        n_count     = r_count;
        n_given     = r_given;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_NO_SPACE, logical_page: '0, frame: '0,
                        free_frames: r_free, last: 1'b1};
        ram_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_res_ready) begin
                    o_cmd_pop = 1'b1;
                    n_id      = i_cmd.id;
                    n_count   = i_cmd.count;
                    n_given   = '0;
                    n_idx     = '0;
                    if (i_cmd.kind == K_REJECT || (i_cmd.kind == K_ALLOC && short_space)) begin
                        o_res_valid = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                if (i_res_ready) begin
                    n_used[first] = 1'b1;
                    ram_we        = 1'b1;
                    n_free        = r_free - 1'b1;
                    n_given       = r_given + 1'b1;
                    o_res_valid   = 1'b1;
                    o_res = '{status: ST_ASSIGNED, logical_page: r_given + 1'b1,
                              frame: first, free_frames: r_free - 1'b1,
                              last: alloc_last};
                end
            end
            S_SWEEP: begin
                n_chk     = 1'b1;
                n_chk_idx = r_idx;
                n_idx     = r_idx + 1'b1;
                if (chk_hit) begin
                    n_used[r_chk_idx] = 1'b0;
                    n_free            = r_free + 1'b1;
                end
            end
            S_REPORT: begin
                if (chk_hit) begin
                    n_used[r_chk_idx] = 1'b0;
                    n_free            = r_free + 1'b1;
                end
                if (!r_chk && i_res_ready) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: ST_RELEASED, logical_page: '0, frame: '0,
                              free_frames: r_free, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_free  <= FREE_BITS'(FRAMES);
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_free  <= n_free;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_count   <= n_count;
        r_given   <= n_given;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
    end

    a_free_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(~r_used) == int'(r_free))
        else $error("free count disagrees with frame map");

    a_alloc_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ALLOC |-> r_free != '0 && !r_used[first])
        else $error("allocation with no free frame");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FREE_BITS'(FRAMES))
        else $error("free count above frame total");

    a_sweep_to_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP && r_idx == LAST_FRAME |=> r_state == S_REPORT && r_chk)
        else $error("sweep did not end in report");

endmodule

>>> design/pfa_result_q.sv
module pfa_result_q import pfa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    input  t_result                i_res,
    output logic                   o_res_ready,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_status,
    output logic [COUNT_BITS-1:0]  o_logical_page,
    output logic [FRAME_BITS-1:0]  o_frame,
    output logic [FREE_BITS-1:0]   o_free_frames,
    output logic                   o_last
);

    localparam int PTR_BITS = $clog2(RES_DEPTH);
    localparam int CNT_BITS = $clog2(RES_DEPTH + 1);

    t_result             r_mem [RES_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic                wr_en, rd_en;
    t_result             head;

    assign o_res_ready    = (r_cnt != CNT_BITS'(RES_DEPTH));
    assign empty          = (r_cnt == '0);
    assign wr_en          = i_res_valid && o_res_ready;
    assign rd_en          = pop && !empty;
    assign head           = r_mem[r_rd];
    assign o_status       = head.status;
    assign o_logical_page = head.logical_page;
    assign o_frame        = head.frame;
    assign o_free_frames  = head.free_frames;
    assign o_last         = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

>>> design/page_frame_allocator_unit.sv
// Allocate: after acceptance the back end enters S_ALLOC, then writes one word per cycle
//   while the result queue has room (each frame from a priority encoder on the in-use map).
// Release: one owner-memory read per frame in S_SWEEP, then one word from S_REPORT.
// No space / bad count: one word, written in the acceptance cycle and readable in the next.
// The back end takes no new command until it is back in S_IDLE.
// Synchronous active-low reset frees every frame at once; owner memory is not cleared.
module page_frame_allocator_unit import pfa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_action,
    input  logic [ID_BITS-1:0]     i_requester_id,
    input  logic [COUNT_BITS-1:0]  i_page_count,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_status,
    output logic [COUNT_BITS-1:0]  o_logical_page,
    output logic [FRAME_BITS-1:0]  o_frame,
    output logic [FREE_BITS-1:0]   o_free_frames,
    output logic                   o_last
);

    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    logic    res_valid, res_ready;
    t_result res;

    pfa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_requester_id (i_requester_id),
        .i_page_count   (i_page_count),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    pfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    pfa_result_q u_resq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .i_res          (res),
        .o_res_ready    (res_ready),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_logical_page (o_logical_page),
        .o_frame        (o_frame),
        .o_free_frames  (o_free_frames),
        .o_last         (o_last)
    );

endmodule
